// File: rtl/gds_pkg.sv
// ----------------------------------------------------------------------------
// gds_pkg - shared types and calendar helpers for the date stepper
// Command and result words, mode and status codes, control bundles between
// the controller and the datapath, and the month-length lookup.
// ----------------------------------------------------------------------------
package gds_pkg;

  localparam logic [13:0] MIN_YEAR = 14'd1582;
  localparam logic [13:0] MAX_YEAR = 14'd9999;

  // Reset date 1582-01-01; 1582 = 15 * 100 + 82, and 15 mod 4 = 3.
  localparam logic [6:0]  RESET_YMOD = 7'd82;
  localparam logic [1:0]  RESET_CMOD = 2'd3;

  // y / 100 = (y * RECIP_100) >> RECIP_SHIFT, exact for all 14-bit years.
  localparam logic [13:0] RECIP_100   = 14'd10486;
  localparam int          RECIP_SHIFT = 20;

  localparam logic [2:0] MODE_LOAD = 3'd0;
  localparam logic [2:0] MODE_NEXT = 3'd1;
  localparam logic [2:0] MODE_PREV = 3'd2;
  localparam logic [2:0] MODE_ADD  = 3'd3;
  localparam logic [2:0] MODE_SUB  = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  typedef struct packed {
    logic [2:0]  mode;
    logic [4:0]  load_day;
    logic [3:0]  load_month;
    logic [13:0] load_year;
    logic [15:0] day_count;
  } cmd_word_t;

  typedef struct packed {
    logic [4:0]  cur_day;
    logic [3:0]  cur_month;
    logic [13:0] cur_year;
    logic [1:0]  status;
  } res_word_t;

  typedef struct packed {
    logic       capture;
    logic       step_add;
    logic       step_sub;
    logic       div;
    logic       commit_work;
    logic       commit_load;
    logic       publish;
    logic [1:0] status;
  } gds_cmd_t;

  typedef struct packed {
    logic add_done;
    logic add_fail;
    logic sub_done;
    logic sub_fail;
    logic load_ok;
    logic out_busy;
  } gds_stat_t;

  // Leap rule from year mod 4, year mod 100 and century mod 4.
  function automatic logic is_leap(input logic [1:0] y4, input logic [6:0] ymod,
                                   input logic [1:0] cmod);
    return ((y4 == 2'd0) && (ymod != 7'd0)) || ((ymod == 7'd0) && (cmod == 2'd0));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// File: rtl/gregorian_date_stepper.sv
// ----------------------------------------------------------------------------
// gregorian_date_stepper - Gregorian calendar date register with stepping
// Holds one date and loads, steps or offsets it by a day count per command.
// ----------------------------------------------------------------------------
// Each command word gives exactly one result word: the stored date after the
// command and a status (ok, invalid load rejected, year range left with the
// date kept). Commands are taken one at a time; cmd_ready is high only while
// no command is in progress. Add and subtract walk the calendar one month per
// clock in the datapath, one step per month boundary crossed. The month walk is
// the only loop; a result sitting unread in the output register holds off the
// next command only at its final handoff. After reset the date is 1582-01-01.
// Leap years follow the 4/100/400 rule, tracked through year mod 100 and
// century mod 4 kept next to the stored year.
// ----------------------------------------------------------------------------
module gregorian_date_stepper import gds_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_word_t cmd_word,
  output logic      res_valid,
  input  logic      res_ready,
  output res_word_t res_word
);

  gds_cmd_t  ctl;
  gds_stat_t stat;

  // Controller: sequence load check, month walk and result handoff.
  gds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .mode      (cmd_word.mode),
    .cmd_ready (cmd_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  // Datapath: hold the date, walk months, check loads, register the result.
  gds_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd_word  (cmd_word),
    .ctl       (ctl),
    .stat      (stat),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res_word  (res_word)
  );

`ifndef SYNTHESIS
  // Drop ready in the cycle after every accepted command.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("command accepted while previous one in progress");

  // Every published date has its month in 1..12, its day in 1..31 and its year in range.
  a_date_legal: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((res_word.cur_month >= 4'd1) && (res_word.cur_month <= 4'd12) &&
                   (res_word.cur_day >= 5'd1) && (res_word.cur_day <= 5'd31) &&
                   (res_word.cur_year >= MIN_YEAR) && (res_word.cur_year <= MAX_YEAR)))
    else $error("result date out of range");

  // Never emit the unused status code.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_word.status == ST_OK || res_word.status == ST_INVALID ||
                   res_word.status == ST_RANGE))
    else $error("bad status code");
`endif

endmodule

// File: rtl/gds_dp.sv
// ----------------------------------------------------------------------------
// gds_dp - date stepper datapath
// Stored date, working copy for the month walk, load check and result
// register.
// ----------------------------------------------------------------------------
module gds_dp import gds_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cmd_word_t cmd_word,
  input  gds_cmd_t  ctl,
  output gds_stat_t stat,
  input  logic      res_ready,
  output logic      res_valid,
  output res_word_t res_word
);

  // Stored date with year mod 100 and century mod 4 kept alongside.
  logic [4:0]  day;
  logic [3:0]  month;
  logic [13:0] year;
  logic [6:0]  ymod;
  logic [1:0]  cmod;

  // Working copy.
  logic signed [17:0] wd;
  logic [3:0]  wm;
  logic [13:0] wy;
  logic [6:0]  wmod;
  logic [1:0]  wcmod;

  // Captured load fields and quotient.
  logic [4:0]  ld;
  logic [3:0]  lm;
  logic [13:0] ly;
  logic [7:0]  lq;

  logic [15:0] step_n;
  logic [4:0]  len_a;
  logic [4:0]  len_s;
  logic [3:0]  nm;
  logic [13:0] ny;
  logic [6:0]  nmod;
  logic [1:0]  ncmod;
  logic [27:0] prod;
  logic [6:0]  lr;
  logic        lleap;
  logic        add_done;
  logic        sub_done;

  always_comb begin
    step_n = ((cmd_word.mode == MODE_NEXT) || (cmd_word.mode == MODE_PREV)) ?
             16'd1 : cmd_word.day_count;
    len_a  = month_len(wm, is_leap(wy[1:0], wmod, wcmod));
    add_done = (wd <= $signed({13'd0, len_a}));
    sub_done = (wd > 18'sd0);
    // Previous month, with year and counters borrowed across January.
    if (wm == 4'd1) begin
      nm = 4'd12;
      ny = wy - 14'd1;
      if (wmod == 7'd0) begin
        nmod  = 7'd99;
        ncmod = wcmod - 2'd1;
      end else begin
        nmod  = wmod - 7'd1;
        ncmod = wcmod;
      end
    end else begin
      nm    = wm - 4'd1;
      ny    = wy;
      nmod  = wmod;
      ncmod = wcmod;
    end
    len_s = month_len(nm, is_leap(ny[1:0], nmod, ncmod));
    prod  = ly * RECIP_100;
    lr    = 7'(ly - 14'(lq) * 14'd100);
    lleap = is_leap(ly[1:0], lr, lq[1:0]);
  end

  assign stat.add_done = add_done;
  assign stat.add_fail = !add_done && (wm == 4'd12) && (wy >= MAX_YEAR);
  assign stat.sub_done = sub_done;
  assign stat.sub_fail = !sub_done && (wm == 4'd1) && (wy <= MIN_YEAR);
  assign stat.load_ok  = (ly >= MIN_YEAR) && (ly <= MAX_YEAR) &&
                         (lm >= 4'd1) && (lm <= 4'd12) &&
                         (ld >= 5'd1) && (ld <= month_len(lm, lleap));
  assign stat.out_busy = res_valid && !res_ready;

  // Working copy and load capture.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      wm    <= month;
      wy    <= year;
      wmod  <= ymod;
      wcmod <= cmod;
      ld    <= cmd_word.load_day;
      lm    <= cmd_word.load_month;
      ly    <= cmd_word.load_year;
      case (cmd_word.mode) inside
        MODE_NEXT, MODE_ADD: begin
          wd <= $signed({13'd0, day}) + $signed({2'd0, step_n});
        end
        default: begin
          wd <= $signed({13'd0, day}) - $signed({2'd0, step_n});
        end
      endcase
    end else if (ctl.step_add && !add_done) begin
      wd <= wd - $signed({13'd0, len_a});
      if (wm == 4'd12) begin
        wm <= 4'd1;
        wy <= wy + 14'd1;
        if (wmod == 7'd99) begin
          wmod  <= 7'd0;
          wcmod <= wcmod + 2'd1;
        end else begin
          wmod <= wmod + 7'd1;
        end
      end else begin
        wm <= wm + 4'd1;
      end
    end else if (ctl.step_sub && !sub_done) begin
      wd    <= wd + $signed({13'd0, len_s});
      wm    <= nm;
      wy    <= ny;
      wmod  <= nmod;
      wcmod <= ncmod;
    end
    if (ctl.div) begin
      lq <= prod[RECIP_SHIFT +: 8];
    end
  end

  // Stored date.
  always_ff @(posedge clk) begin
    if (rst) begin
      day   <= 5'd1;
      month <= 4'd1;
      year  <= MIN_YEAR;
      ymod  <= RESET_YMOD;
      cmod  <= RESET_CMOD;
    end else if (ctl.commit_work) begin
      day   <= wd[4:0];
      month <= wm;
      year  <= wy;
      ymod  <= wmod;
      cmod  <= wcmod;
    end else if (ctl.commit_load) begin
      day   <= ld;
      month <= lm;
      year  <= ly;
      ymod  <= lr;
      cmod  <= lq[1:0];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.publish) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.publish) begin
      res_word.cur_day   <= day;
      res_word.cur_month <= month;
      res_word.cur_year  <= year;
      res_word.status    <= ctl.status;
    end
  end

endmodule

// File: rtl/gds_ctrl.sv
// ----------------------------------------------------------------------------
// gds_ctrl - date stepper controller
// Sequences load checks and month walks and hands each result to the
// output register.
// ----------------------------------------------------------------------------
module gds_ctrl import gds_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  input  logic [2:0] mode,
  output logic      cmd_ready,
  input  gds_stat_t stat,
  output gds_cmd_t  ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LDIV,
    S_LCHK,
    S_ADD,
    S_SUB,
    S_FIN
  } state_t;

  state_t     state;
  logic [1:0] code;

  assign cmd_ready = (state == S_IDLE);

  always_comb begin
    ctl             = '0;
    ctl.status      = code;
    ctl.capture     = (state == S_IDLE) && cmd_valid;
    ctl.div         = (state == S_LDIV);
    ctl.step_add    = (state == S_ADD);
    ctl.step_sub    = (state == S_SUB);
    ctl.commit_work = ((state == S_ADD) && stat.add_done) ||
                      ((state == S_SUB) && stat.sub_done);
    ctl.commit_load = (state == S_LCHK) && stat.load_ok;
    ctl.publish     = (state == S_FIN) && !stat.out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      code  <= ST_OK;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            code <= ST_OK;
            case (mode) inside
              MODE_LOAD:           state <= S_LDIV;
              MODE_NEXT, MODE_ADD: state <= S_ADD;
              MODE_PREV, MODE_SUB: state <= S_SUB;
              default:             state <= S_FIN;
            endcase
          end
        end
        S_LDIV: state <= S_LCHK;
        S_LCHK: begin
          code  <= stat.load_ok ? ST_OK : ST_INVALID;
          state <= S_FIN;
        end
        S_ADD: begin
          if (stat.add_done) begin
            state <= S_FIN;
          end else if (stat.add_fail) begin
            code  <= ST_RANGE;
            state <= S_FIN;
          end
        end
        S_SUB: begin
          if (stat.sub_done) begin
            state <= S_FIN;
          end else if (stat.sub_fail) begin
            code  <= ST_RANGE;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!stat.out_busy) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
